// ===== design/pild_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the list block.
`timescale 1ns / 1ps
`default_nettype none
package pild_pkg;

	// Storage geometry
	localparam int DEPTH      = 64;
	localparam int POINT_BITS = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = 7;
	localparam int POS_W      = 8;
	localparam int CAP_FLOOR  = 5;

	// Command codes
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // capture an input transfer
		logic shift_load;  // set up the shift loop
		logic shift_en;    // run one shift step
		logic read_issue;  // read the entry at the position
		logic finish;      // commit the command and load the result
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_shift;
		logic read_ok;
		logic shift_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== design/positional_insert_delete_list.sv =====
// Sequence: accept, decode, the shift loop (each entry moved, then the last write and the done
// check), then commit; the result is registered at commit and is on the output in the cycle
// after commit. With no shift, decode goes straight to commit.
// One command at a time: a new command is accepted only after the previous one has committed,
// with the shift loop moving one entry per cycle through the single-write, single-read entry RAM.
// Reset clears count, capacity and the default word, and sets min_capacity to 4;
// entry RAM contents are undefined until written and get no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module positional_insert_delete_list (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,     // [7:0] position, [39:8] point_value
	input  wire logic [1:0]  s_tuser,     // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,     // [31:0] read_value, [38:32] entry_count,
	                                      // [45:39] logical_capacity, [47:46] zero
	output logic [1:0]       m_tuser,     // [1:0] status
	input  wire logic        cfg_wr_en,
	input  wire logic [6:0]  cfg_wr_data  // min_capacity
);

	pild_pkg::ctl_cmd_t ctl;
	pild_pkg::dp_stat_t stat;

	logic [1:0]                        out_status;
	logic [pild_pkg::POINT_BITS-1:0]   out_read_value;
	logic [pild_pkg::CNT_W-1:0]        out_count;
	logic [pild_pkg::CNT_W-1:0]        out_capacity;

	pild_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.ctl       (ctl)
	);

	pild_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.in_command     (s_tuser),
		.in_position    (s_tdata[7:0]),
		.in_point       (s_tdata[39:8]),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_status     (out_status),
		.out_read_value (out_read_value),
		.out_count      (out_count),
		.out_capacity   (out_capacity)
	);

	// Pack the result transfer
	assign m_tuser = out_status;
	assign m_tdata = {2'b00, out_capacity, out_count, out_read_value};

endmodule
`default_nettype wire

// ===== design/pild_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pild_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, hold data when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/pild_datapath.sv =====
// Datapath: command registers, count and capacity, entry RAM, shift loop and result register.
`timescale 1ns / 1ps
`default_nettype none
module pild_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pild_pkg::ctl_cmd_t           ctl,
	output pild_pkg::dp_stat_t                stat,
	input  wire logic [1:0]                   in_command,
	input  wire logic [pild_pkg::POS_W-1:0]   in_position,
	input  wire logic [pild_pkg::POINT_BITS-1:0] in_point,
	input  wire logic                         cfg_wr_en,
	input  wire logic [pild_pkg::CNT_W-1:0]   cfg_wr_data,
	output logic [1:0]                        out_status,
	output logic [pild_pkg::POINT_BITS-1:0]   out_read_value,
	output logic [pild_pkg::CNT_W-1:0]        out_count,
	output logic [pild_pkg::CNT_W-1:0]        out_capacity
);

	localparam int AW = pild_pkg::ADDR_W;
	localparam int CW = pild_pkg::CNT_W;
	localparam int PB = pild_pkg::POINT_BITS;

	// Captured command
	pild_pkg::cmd_t              cmd_q;
	logic [pild_pkg::POS_W-1:0]  pos_q;
	logic [PB-1:0]               val_q;

	// Architectural state
	logic [CW-1:0] count_q;
	logic [CW-1:0] cap_q;
	logic [PB-1:0] dflt_q;
	logic [CW-1:0] min_cap_q;

	// Shift loop
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CW-1:0] steps_q;
	logic          pend_q;
	logic          desc_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [PB-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [PB-1:0] ram_rdata;

	// Decode
	logic          pos_neg;
	logic [CW-1:0] pos_u;
	logic [AW-1:0] pos_a;
	logic          ins_range;
	logic          full;
	logic          idx_ok;
	logic          step_live;

	// Commit values
	logic [CW-1:0]   first_cap;
	logic [CW-1:0]   cap0;
	logic [CW:0]     dbl;
	logic [CW-1:0]   grown;
	logic [CW-1:0]   cnt_inc;
	logic [CW-1:0]   cnt_dec;
	logic [CW-1:0]   cnt_nx;
	logic [CW-1:0]   cap_nx;
	pild_pkg::status_t status_nx;
	logic [PB-1:0]   rd_nx;
	logic            fin_we;

	// Range checks on the captured position
	always_comb begin
		pos_neg   = pos_q[pild_pkg::POS_W-1];
		pos_u     = CW'(pos_q[pild_pkg::POS_W-2:0]);
		pos_a     = pos_u[AW-1:0];
		ins_range = !pos_neg && (pos_u <= count_q);
		full      = count_q >= CW'(pild_pkg::DEPTH);
		idx_ok    = !pos_neg && (pos_u < count_q);
		cnt_inc   = count_q + CW'(1);
		cnt_dec   = count_q - CW'(1);
		step_live = ctl.shift_en && (steps_q != '0);
	end

	assign stat.need_shift = ((cmd_q == pild_pkg::CMD_INSERT) && ins_range && !full
	                          && (pos_u != count_q))
	                      || ((cmd_q == pild_pkg::CMD_REMOVE) && idx_ok
	                          && ((pos_u + CW'(1)) != count_q));
	assign stat.read_ok    = (cmd_q == pild_pkg::CMD_READ) && idx_ok;
	assign stat.shift_done = (steps_q == '0) && !pend_q;

	// Capacity on insert: first capacity, then doubling clamped to the store
	always_comb begin
		if (min_cap_q == '0) begin
			first_cap = CW'(1);
		end else if (min_cap_q > CW'(pild_pkg::DEPTH)) begin
			first_cap = CW'(pild_pkg::DEPTH);
		end else begin
			first_cap = min_cap_q;
		end
		cap0 = (cap_q == '0) ? first_cap : cap_q;
		dbl  = {count_q, 1'b0};
		if (dbl > (CW + 1)'(pild_pkg::DEPTH)) begin
			grown = CW'(pild_pkg::DEPTH);
		end else begin
			grown = dbl[CW-1:0];
		end
		if (grown < cnt_inc) begin
			grown = cnt_inc;
		end
	end

	// Commit outcome per command
	always_comb begin
		cnt_nx    = count_q;
		cap_nx    = cap_q;
		status_nx = pild_pkg::ST_DONE;
		rd_nx     = '0;
		fin_we    = 1'b0;
		case (cmd_q)
			pild_pkg::CMD_INSERT: begin
				if (!ins_range) begin
					status_nx = pild_pkg::ST_RANGE;
				end else if (full) begin
					status_nx = pild_pkg::ST_FULL;
				end else begin
					fin_we = 1'b1;
					cnt_nx = cnt_inc;
					cap_nx = (count_q >= cap0) ? grown : cap0;
				end
			end
			pild_pkg::CMD_REMOVE: begin
				if (!idx_ok) begin
					status_nx = pild_pkg::ST_RANGE;
				end else begin
					cnt_nx = cnt_dec;
					if ((cnt_dec < (cap_q >> 2)) && ((cap_q >> 1) >= CW'(pild_pkg::CAP_FLOOR)))
					begin
						cap_nx = cap_q >> 1;
					end
				end
			end
			pild_pkg::CMD_READ: begin
				if (idx_ok) begin
					rd_nx = ram_rdata;
				end else begin
					rd_nx     = dflt_q;
					status_nx = pild_pkg::ST_RANGE;
				end
			end
			default: begin
				if (idx_ok) begin
					fin_we = 1'b1;
				end else begin
					status_nx = pild_pkg::ST_RANGE;
				end
			end
		endcase
	end

	// RAM port steering: shift loop or the final access
	always_comb begin
		ram_re    = step_live || ctl.read_issue;
		ram_raddr = ctl.shift_en ? rd_ptr_q : pos_a;
		if (ctl.finish) begin
			ram_we    = fin_we;
			ram_waddr = pos_a;
			ram_wdata = val_q;
		end else begin
			ram_we    = ctl.shift_en && pend_q;
			ram_waddr = wr_ptr_q;
			ram_wdata = ram_rdata;
		end
	end

	pild_ram #(
		.WIDTH (PB),
		.DEPTH (pild_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Capture the input transfer
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= pild_pkg::cmd_t'(in_command);
			pos_q <= in_position;
			val_q <= in_point;
		end
	end

	// Shift pointers: read one entry per cycle, write it back in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			pend_q  <= 1'b0;
		end else if (ctl.shift_load) begin
			steps_q <= (cmd_q == pild_pkg::CMD_INSERT) ? (count_q - pos_u)
			                                           : (count_q - pos_u - CW'(1));
			pend_q  <= 1'b0;
		end else if (ctl.shift_en) begin
			pend_q <= step_live;
			if (step_live) begin
				steps_q <= steps_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_load) begin
			desc_q   <= (cmd_q == pild_pkg::CMD_INSERT);
			rd_ptr_q <= (cmd_q == pild_pkg::CMD_INSERT) ? cnt_dec[AW-1:0]
			                                            : (pos_a + AW'(1));
		end else if (step_live) begin
			rd_ptr_q <= desc_q ? (rd_ptr_q - AW'(1)) : (rd_ptr_q + AW'(1));
			wr_ptr_q <= desc_q ? (rd_ptr_q + AW'(1)) : (rd_ptr_q - AW'(1));
		end
	end

	// Count, capacity, default word and minimum capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cap_q     <= '0;
			dflt_q    <= '0;
			min_cap_q <= CW'(4);
		end else begin
			if (cfg_wr_en) begin
				min_cap_q <= cfg_wr_data;
			end
			if (ctl.finish) begin
				count_q <= cnt_nx;
				cap_q   <= cap_nx;
				if ((cmd_q == pild_pkg::CMD_WRITE) && !idx_ok) begin
					dflt_q <= val_q;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_status     <= status_nx;
			out_read_value <= rd_nx;
			out_count      <= cnt_nx;
			out_capacity   <= cap_nx;
		end
	end

endmodule
`default_nettype wire

// ===== design/pild_ctrl.sv =====
// Controller: sequences accept, decode, shift loop and commit, and owns the output valid.
`timescale 1ns / 1ps
`default_nettype none
module pild_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire pild_pkg::dp_stat_t stat,
	output pild_pkg::ctl_cmd_t      ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Commands for the current state
	always_comb begin
		ctl            = '0;
		ctl.load       = (state_q == S_IDLE) && in_valid;
		ctl.shift_load = (state_q == S_EXEC) && stat.need_shift;
		ctl.read_issue = (state_q == S_EXEC) && stat.read_ok;
		ctl.shift_en   = (state_q == S_SHIFT);
		ctl.finish     = (state_q == S_FINISH) && out_free;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= stat.need_shift ? S_SHIFT : S_FINISH;
				end
				S_SHIFT: begin
					if (stat.shift_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
